// ===== design/ftl_pkg.sv =====
// Types, codes and constants shared by the forwarding table lookup design.
`timescale 1ns / 1ps
`default_nettype none
package ftl_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int FIELD_W         = 16;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [1:0] STATUS_LOOKUP    = 2'd3;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_HOP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_VALID = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_DELAY = 2'd2;

   typedef struct packed {
      logic               mode;
      logic [FIELD_W-1:0] dest_address;
      logic [FIELD_W-1:0] next_hop;
      logic [FIELD_W-1:0] delay;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               hit;
      logic [FIELD_W-1:0] hop_out;
      logic               hop_valid;
      logic [FIELD_W-1:0] delay_out;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] dest_address;
      logic [FIELD_W-1:0] next_hop;
      logic [FIELD_W-1:0] delay;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage
`default_nettype wire

// ===== design/ftl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module ftl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/forwarding_table_lookup_core.sv =====
// Top level of the exact-match forwarding table with a default route.
// Use: drive req_data and raise start while busy is low; the beat is taken at
// that edge. Mode insert appends the address, hop and delay unless the table
// is full (checked first) or the address is already stored. Mode lookup
// returns the stored hop and delay of the first matching slot, or else the
// default hop and delay from the configuration registers.
// Every beat yields exactly one result, shown on rsp_data for one cycle with
// rsp_strobe high; the receiver cannot hold it off, and it always takes it.
// Timing: an insert into a full table answers in the cycle after start. Every
// other beat scans the filled slots one per cycle through the entry RAM read
// port and answers after the first matching slot, or after the last filled
// slot on a miss. busy is high for the scan; the next beat may start in the
// cycle its result is shown.
// Configuration: csr_we, csr_index and csr_wdata write a register at once;
// they are to be written only while the block is idle, which the user must
// ensure, as the block does not enforce it. Unknown indexes are ignored.
// Reset (synchronous, active high) empties the table and clears the defaults;
// no clearing pass is needed, as slots at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none
module forwarding_table_lookup_core
   import ftl_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [FIELD_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;
   logic [FIELD_W-1:0] def_hop_ff;
   logic               def_valid_ff;
   logic [FIELD_W-1:0] def_delay_ff;

   logic               ram_wr_en;
   logic               ram_rd_en;
   entry_type          ram_rd_data;
   entry_type          ram_wr_data;
   logic               match;

   assign ram_wr_data = '{dest_address: req_ff.dest_address,
                          next_hop:     req_ff.next_hop,
                          delay:        req_ff.delay};

   ftl_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign match = rd_valid_ff && (ram_rd_data.dest_address == req_ff.dest_address);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         def_hop_ff    <= '0;
         def_valid_ff  <= 1'b0;
         def_delay_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEFAULT_HOP:   def_hop_ff   <= csr_wdata;
               CSR_DEFAULT_VALID: def_valid_ff <= csr_wdata[0];
               CSR_DEFAULT_DELAY: def_delay_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_valid_in   = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               idx_in = '0;
               if (req_data.mode == MODE_INSERT && count_ff == FULL_COUNT) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = STATUS_FULL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               idx_in      = idx_ff + CNT_W'(1);
            end
            if (match) begin
               state_in      = ST_IDLE;
               rd_valid_in   = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               if (req_ff.mode == MODE_INSERT) begin
                  rsp_in.status = STATUS_DUPLICATE;
               end else begin
                  rsp_in.status    = STATUS_LOOKUP;
                  rsp_in.hit       = 1'b1;
                  rsp_in.hop_out   = ram_rd_data.next_hop;
                  rsp_in.hop_valid = 1'b1;
                  rsp_in.delay_out = ram_rd_data.delay;
               end
            end else if (!rd_valid_ff && idx_ff == count_ff) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               if (req_ff.mode == MODE_INSERT) begin
                  ram_wr_en     = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  rsp_in.status = STATUS_INSERTED;
               end else begin
                  rsp_in.status    = STATUS_LOOKUP;
                  rsp_in.hop_out   = def_valid_ff ? def_hop_ff : '0;
                  rsp_in.hop_valid = def_valid_ff;
                  rsp_in.delay_out = def_delay_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table capacity");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy)
      else $error("result beat shown while a scan is still running");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("table write without an entry count step");

   a_start_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe_ff))
      else $error("accepted beat neither scanned nor answered");

endmodule
`default_nettype wire
